// ----- rtl/ltn_pkg.sv -----
// ltn_pkg: types and codes shared by the tier negotiation controller.
// No dependencies; every rtl module imports it.
`default_nettype none

package ltn_pkg;

  localparam int TierW = 3;
  localparam int SnrW  = 12;

  typedef enum logic [1:0] {
    S_IDLE      = 2'd0,
    S_PROBING   = 2'd1,
    S_ACTIVE    = 2'd2,
    S_RETUNING  = 2'd3
  } ltn_state_t;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_FRAME = 2'd1,
    FN_SNR   = 2'd2,
    FN_TICK  = 2'd3
  } func_t;

  // received frame types
  localparam logic [2:0] FR_PROBE  = 3'd0;
  localparam logic [2:0] FR_ACK    = 3'd1;
  localparam logic [2:0] FR_RETUNE = 3'd2;
  localparam logic [2:0] FR_NAK    = 3'd3;

  // transmitted frame types
  localparam logic [1:0] SEND_PROBE  = 2'd0;
  localparam logic [1:0] SEND_ACK    = 2'd1;
  localparam logic [1:0] SEND_RETUNE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TIER_COUNT = 2'd0;
  localparam logic [1:0] CFG_THRESHOLDS = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;
  localparam logic [1:0] CFG_RETRIES    = 2'd3;

  typedef struct packed {
    func_t                  func;
    logic                   crc_ok;
    logic [2:0]             frm_kind;
    logic [TierW-1:0]       frame_tier;
    logic [TierW-1:0]       frame_max_tier;
    logic signed [SnrW-1:0] snr_value;
    logic                   acm_moved;
    logic [TierW-1:0]       acm_tier;
  } evt_t;

  typedef struct packed {
    logic [TierW-1:0] max_tier;
    logic [63:0]      thresholds;
    logic [7:0]       timeout_ticks;
    logic [3:0]       max_retries;
  } cfg_t;

  typedef struct packed {
    logic             send_valid;
    logic [1:0]       send_type;
    logic [TierW-1:0] send_tier;
    logic [TierW-1:0] send_max_tier;
    logic             force_valid;
    logic [TierW-1:0] force_tgt;
    logic             notify_valid;
    ltn_state_t       link_state;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/link_tier_negotiator.sv -----
// link_tier_negotiator: top level with configuration registers, event beat
// register and result beat register around ltn_fsm. Depends on ltn_pkg.
// An accepted input beat is held in the event register, its result in the result
// register. Throughput: one event per cycle unless out_stall backs up the
// pipeline; the state update and result sit in a single combinational pass.
// Reset (rst_n low, synchronous): idle state, counters and SNR cleared,
// registers to tier_count 8, thresholds 0, timeout 3, retries 3.
`default_nettype none

module link_tier_negotiator #(
  parameter int MAX_TIERS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic        in_crc_ok,
  input  wire logic [2:0]  in_frame_type,
  input  wire logic [2:0]  in_frame_tier,
  input  wire logic [2:0]  in_frame_max_tier,
  input  wire logic signed [11:0] in_snr_value,
  input  wire logic        in_acm_moved,
  input  wire logic [2:0]  in_acm_tier,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_send_valid,
  output logic [1:0]       out_send_type,
  output logic [2:0]       out_send_tier,
  output logic [2:0]       out_send_max_tier,
  output logic             out_force_valid,
  output logic [2:0]       out_force_tier,
  output logic             out_notify_valid,
  output logic [1:0]       out_link_state
);
  import ltn_pkg::*;

  localparam logic [TierW-1:0] MaxTier = TierW'(MAX_TIERS - 1);

  logic [3:0]  tier_count_r;
  logic [63:0] thresholds_r;
  logic [7:0]  timeout_r;
  logic [3:0]  retries_r;
  logic        evt_valid_r;
  evt_t        evt_r;
  logic        res_valid_r;
  res_t        res_r;
  res_t        res;
  cfg_t        cfg;
  logic        res_load;
  logic        advance;
  logic [3:0]  count_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tier_count_r <= 4'd8;
      thresholds_r <= '0;
      timeout_r    <= 8'd3;
      retries_r    <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIER_COUNT: tier_count_r <= cfg_data[3:0];
        CFG_THRESHOLDS: thresholds_r <= cfg_data;
        CFG_TIMEOUT:    timeout_r    <= cfg_data[7:0];
        CFG_RETRIES:    retries_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign count_m1 = tier_count_r - 4'd1;

  always_comb begin
    if (tier_count_r == 4'd0) begin
      cfg.max_tier = '0;
    end else if (count_m1 > 4'(MAX_TIERS - 1)) begin
      cfg.max_tier = MaxTier;
    end else begin
      cfg.max_tier = count_m1[TierW-1:0];
    end
    cfg.thresholds    = thresholds_r;
    cfg.timeout_ticks = timeout_r;
    cfg.max_retries   = retries_r;
  end

  assign res_load = !res_valid_r || !out_stall;
  assign advance  = evt_valid_r && res_load;
  assign in_stall = evt_valid_r && !res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
    end else if (!in_stall) begin
      evt_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      evt_r.func           <= func_t'(in_func);
      evt_r.crc_ok         <= in_crc_ok;
      evt_r.frm_kind       <= in_frame_type;
      evt_r.frame_tier     <= in_frame_tier;
      evt_r.frame_max_tier <= in_frame_max_tier;
      evt_r.snr_value      <= in_snr_value;
      evt_r.acm_moved      <= in_acm_moved;
      evt_r.acm_tier       <= in_acm_tier;
    end
  end

  ltn_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .evt     (evt_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= evt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_send_valid    = res_r.send_valid;
  assign out_send_type     = res_r.send_type;
  assign out_send_tier     = res_r.send_tier;
  assign out_send_max_tier = res_r.send_max_tier;
  assign out_force_valid   = res_r.force_valid;
  assign out_force_tier    = res_r.force_tgt;
  assign out_notify_valid  = res_r.notify_valid;
  assign out_link_state    = res_r.link_state;

`ifndef NO_ASSERTIONS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && out_stall |=> res_valid_r && $stable(res_r))
    else $error("stalled result beat changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> evt_valid_r && res_valid_r)
    else $error("input stalled with room in the pipeline");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_valid_r)
    else $error("processed event produced no result beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/ltn_tier_pick.sv -----
// ltn_tier_pick: highest tier up to min(our max, peer max) whose SNR
// threshold the stored SNR meets, else tier 0. Depends on ltn_pkg.
`default_nettype none

module ltn_tier_pick (
  input  wire logic signed [ltn_pkg::SnrW-1:0] snr,
  input  wire logic [63:0]                     thresholds,
  input  wire logic [ltn_pkg::TierW-1:0]       our_max,
  input  wire logic [ltn_pkg::TierW-1:0]       far_max,
  output logic      [ltn_pkg::TierW-1:0]       tier
);
  import ltn_pkg::*;

  logic [TierW-1:0] upper;

  assign upper = (far_max < our_max) ? far_max : our_max;

  always_comb begin
    logic signed [SnrW-1:0] thr;
    tier = '0;
    for (int i = 0; i < 8; i++) begin
      thr = $signed({thresholds[8*i +: 8], 4'b0000});
      if ((TierW'(i) <= upper) && (snr >= thr)) begin
        tier = TierW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ltn_fsm.sv -----
// ltn_fsm: negotiation state, agreed tier, retry and tick counters, last SNR,
// and the result of one event. Depends on ltn_pkg and ltn_tier_pick.
`default_nettype none

module ltn_fsm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire ltn_pkg::evt_t evt,
  input  wire ltn_pkg::cfg_t cfg,
  output ltn_pkg::res_t      res
);
  import ltn_pkg::*;

  ltn_state_t             state_r, state_nxt;
  logic [TierW-1:0]       agreed_r, agreed_nxt;
  logic [3:0]             retry_r, retry_nxt;
  logic [7:0]             tick_r, tick_nxt;
  logic signed [SnrW-1:0] snr_r, snr_nxt;
  logic [TierW-1:0]       pick;

  ltn_tier_pick u_pick (
    .snr        (snr_r),
    .thresholds (cfg.thresholds),
    .our_max    (cfg.max_tier),
    .far_max    (evt.frame_max_tier),
    .tier       (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      agreed_r <= '0;
      retry_r  <= '0;
      tick_r   <= '0;
      snr_r    <= '0;
    end else if (advance) begin
      state_r  <= state_nxt;
      agreed_r <= agreed_nxt;
      retry_r  <= retry_nxt;
      tick_r   <= tick_nxt;
      snr_r    <= snr_nxt;
    end
  end

  always_comb begin
    logic             agree;
    logic [TierW-1:0] t;
    state_nxt  = state_r;
    agreed_nxt = agreed_r;
    retry_nxt  = retry_r;
    tick_nxt   = tick_r;
    snr_nxt    = snr_r;
    agree      = 1'b0;
    t          = (evt.frame_tier > cfg.max_tier) ? cfg.max_tier : evt.frame_tier;
    res        = '0;

    case (evt.func)
      FN_START: begin
        if (state_r == S_IDLE) begin
          res.send_valid = 1'b1;
          res.send_type  = SEND_PROBE;
          state_nxt      = S_PROBING;
          retry_nxt      = '0;
          tick_nxt       = '0;
        end
      end
      FN_FRAME: begin
        if (evt.crc_ok) begin
          case (evt.frm_kind)
            FR_PROBE: begin
              t              = pick;
              res.send_valid = 1'b1;
              res.send_type  = SEND_ACK;
              res.send_tier  = pick;
              agree          = 1'b1;
            end
            FR_ACK: begin
              agree = (state_r == S_PROBING) || (state_r == S_RETUNING);
            end
            FR_RETUNE: begin
              res.send_valid = 1'b1;
              res.send_type  = SEND_ACK;
              res.send_tier  = t;
              agree          = 1'b1;
            end
            FR_NAK: begin
              agreed_nxt       = '0;
              res.force_valid  = 1'b1;
              res.force_tgt    = '0;
              res.notify_valid = 1'b1;
              state_nxt        = S_IDLE;
            end
            default: ;
          endcase
          if (agree) begin
            agreed_nxt       = t;
            res.force_valid  = 1'b1;
            res.force_tgt    = t;
            res.notify_valid = 1'b1;
            state_nxt        = S_ACTIVE;
          end
        end
      end
      FN_SNR: begin
        snr_nxt = evt.snr_value;
        if ((state_r == S_ACTIVE) && evt.acm_moved && (evt.acm_tier != agreed_r)) begin
          res.send_valid = 1'b1;
          res.send_type  = SEND_RETUNE;
          res.send_tier  = evt.acm_tier;
          state_nxt      = S_RETUNING;
          tick_nxt       = '0;
        end
      end
      FN_TICK: begin
        if ((state_r == S_PROBING) || (state_r == S_RETUNING)) begin
          if (tick_r >= cfg.timeout_ticks) begin
            if (state_r == S_PROBING) begin
              if (retry_r < cfg.max_retries) begin
                retry_nxt      = retry_r + 4'd1;
                res.send_valid = 1'b1;
                res.send_type  = SEND_PROBE;
                tick_nxt       = '0;
              end else begin
                state_nxt = S_IDLE;
              end
            end else begin
              res.force_valid = 1'b1;
              res.force_tgt   = agreed_r;
              state_nxt       = S_ACTIVE;
            end
          end else begin
            tick_nxt = tick_r + 8'd1;
          end
        end
      end
      default: ;
    endcase

    res.send_max_tier = res.send_valid ? cfg.max_tier : '0;
    res.link_state    = state_nxt;
  end

`ifndef NO_ASSERTIONS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) && $stable(agreed_r) && $stable(tick_r))
    else $error("negotiation state moved without an event");

  a_notify_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.notify_valid |=> (state_r == S_ACTIVE) || (state_r == S_IDLE))
    else $error("agreement did not settle in active or idle");

  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (evt.func == FN_TICK) && (state_r == S_IDLE) |=> state_r == S_IDLE)
    else $error("tick left the idle state");

  a_snr_stored: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (evt.func == FN_SNR) |=> snr_r == $past(evt.snr_value))
    else $error("SNR update not stored");

  a_force_on_notify: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.notify_valid |=> agreed_r == $past(res.force_tgt))
    else $error("agreed tier differs from forced tier");
`endif

endmodule

`default_nettype wire
